[sv/msfp_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the motor status frame parser
// no dependencies

package msfp_pkg;

  // frame layout
  localparam int          FRAME_LEN = 17;
  localparam logic [7:0]  HDR0      = 8'h41;
  localparam logic [7:0]  HDR1      = 8'h54;
  localparam int          IDX_ID_HI = 3;
  localparam int          IDX_ID_LO = 4;
  localparam int          IDX_POS   = 7;
  localparam int          IDX_VEL   = 9;
  localparam int          IDX_TRQ   = 11;
  localparam int          IDX_TMP   = 13;

  // configuration register indexes
  localparam int          REG_IDX_W     = 3;
  localparam logic [2:0]  REG_SLOT_IDS  = 3'd0;
  localparam logic [2:0]  REG_SLOT_CNT  = 3'd1;
  localparam logic [2:0]  REG_POS_MIN   = 3'd2;
  localparam logic [2:0]  REG_POS_MAX   = 3'd3;
  localparam logic [2:0]  REG_VEL_MIN   = 3'd4;
  localparam logic [2:0]  REG_VEL_MAX   = 3'd5;
  localparam logic [2:0]  REG_TRQ_MIN   = 3'd6;
  localparam logic [2:0]  REG_TRQ_MAX   = 3'd7;

  // range defaults, signed q16.16
  localparam logic signed [31:0] POS_MIN_RST = -32'sd819200;
  localparam logic signed [31:0] POS_MAX_RST = 32'sd819200;
  localparam logic signed [31:0] VEL_MIN_RST = -32'sd1966080;
  localparam logic signed [31:0] VEL_MAX_RST = 32'sd1966080;
  localparam logic signed [31:0] TRQ_MIN_RST = -32'sd786432;
  localparam logic signed [31:0] TRQ_MAX_RST = 32'sd786432;

  // scaled lanes
  localparam int LANES    = 3;
  localparam int LANE_POS = 0;
  localparam int LANE_VEL = 1;
  localparam int LANE_TRQ = 2;

  // divide by 65535: bias keeps the dividend positive, removed again from the quotient
  localparam logic [50:0] DIV_BIAS  = 51'h3_FFFC_0000_0000;  // 65535 << 34
  localparam logic [35:0] Q_BIAS    = 36'h4_0000_0000;       // 1 << 34
  localparam logic [49:0] HALF_STEP = 50'd32767;
  localparam logic [17:0] DIV_C1    = 18'd65535;
  localparam logic [17:0] DIV_C2    = 18'd131070;
  localparam logic [17:0] DIV_C3    = 18'd196605;

  // temperature: (raw << 16) + 5 = 10 * raw * 6553 + (6 * raw + 5)
  localparam logic [28:0] TEMP_MUL   = 29'd6553;
  localparam logic [18:0] TEMP_SIX   = 19'd6;
  localparam logic [18:0] TEMP_RND   = 19'd5;
  localparam logic [38:0] RECIP10    = 39'd838861;  // ceil(2^23 / 10)
  localparam int          RECIP10_SH = 23;

  typedef logic signed [31:0] q16_t;
  typedef logic [28:0]        temp_t;
  typedef logic [15:0]        raw_t;

endpackage

[sv/motor_status_frame_parser_unit.sv]
`timescale 1ns / 1ps
// motor status frame parser: header hunt, frame capture, slot match and scaling
// depends on msfp_pkg
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | rx_byte
//  out      | out_valid / out_stall | motor_slot, position_val, speed_val,
//           |                       | torque_val, temp_val, last_of_frame
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready is always high)
//
// one byte is taken per cycle while in_stall is low. the last byte of a frame starts
// the arithmetic pipeline; once the frame leaves the last stage, out_valid rises if
// a slot matched, and results transfer one per cycle per match while out_stall is
// low. in_stall rises only on the last frame byte while the previous frame is still
// in the pipeline or still has results waiting; all other bytes pass freely.
// reset (rst, synchronous) returns to header hunting and loads the range defaults.

module motor_status_frame_parser_unit
  import msfp_pkg::*;
#(
  parameter int MAX_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // byte input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           motor_slot,
  output logic signed [31:0]   position_val,
  output logic signed [31:0]   speed_val,
  output logic signed [31:0]   torque_val,
  output logic [28:0]          temp_val,
  output logic                 last_of_frame,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // frame phase codes
  localparam logic [4:0] PH_HUNT = 5'd0;
  localparam logic [4:0] PH_HDR  = 5'd1;
  localparam logic [4:0] PH_DATA = 5'd2;
  localparam logic [4:0] PH_LAST = 5'(FRAME_LEN - 1);

  localparam int STAGES = 8;

  // ---------------------------------------------------------------- configuration
  logic [63:0] slot_id_table;
  logic [3:0]  slot_count;
  q16_t        pos_min, pos_max, vel_min, vel_max, trq_min, trq_max;
  q16_t        lane_lo [LANES];
  q16_t        lane_hi [LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_id_table <= '0;
      slot_count    <= '0;
      pos_min       <= POS_MIN_RST;
      pos_max       <= POS_MAX_RST;
      vel_min       <= VEL_MIN_RST;
      vel_max       <= VEL_MAX_RST;
      trq_min       <= TRQ_MIN_RST;
      trq_max       <= TRQ_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOT_IDS: slot_id_table <= cfg_data;
        REG_SLOT_CNT: slot_count    <= cfg_data[3:0];
        REG_POS_MIN:  pos_min       <= cfg_data[31:0];
        REG_POS_MAX:  pos_max       <= cfg_data[31:0];
        REG_VEL_MIN:  vel_min       <= cfg_data[31:0];
        REG_VEL_MAX:  vel_max       <= cfg_data[31:0];
        REG_TRQ_MIN:  trq_min       <= cfg_data[31:0];
        REG_TRQ_MAX:  trq_max       <= cfg_data[31:0];
        default:      ;
      endcase
    end
  end

  assign lane_lo[LANE_POS] = pos_min;
  assign lane_hi[LANE_POS] = pos_max;
  assign lane_lo[LANE_VEL] = vel_min;
  assign lane_hi[LANE_VEL] = vel_max;
  assign lane_lo[LANE_TRQ] = trq_min;
  assign lane_hi[LANE_TRQ] = trq_max;

  // ---------------------------------------------------------------- frame capture
  logic [4:0]           phase, phase_next;
  logic [7:0]           frame_store [FRAME_LEN];
  logic                 in_xfer;
  logic                 launch;
  logic                 busy;
  logic [STAGES-1:0]    s_vld;
  logic [MAX_SLOTS-1:0] pend, pend_next;

  // any frame still in flight or still emitting blocks the next frame's last byte
  assign busy     = (|s_vld) || (|pend);
  assign in_stall = (phase == PH_LAST) && busy;
  assign in_xfer  = in_valid && !in_stall;
  assign launch   = in_xfer && (phase == PH_LAST);

  always_comb begin
    phase_next = phase;
    if (phase == PH_HUNT || phase > PH_LAST) begin
      phase_next = (rx_byte == HDR0) ? PH_HDR : PH_HUNT;
    end else if (phase == PH_HDR) begin
      // a repeated 0x41 keeps waiting for the second header byte
      if (rx_byte == HDR1) begin
        phase_next = PH_DATA;
      end else if (rx_byte != HDR0) begin
        phase_next = PH_HUNT;
      end
    end else if (phase == PH_LAST) begin
      phase_next = PH_HUNT;
    end else begin
      phase_next = phase + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else if (in_xfer) begin
      phase <= phase_next;
    end
  end

  // only data bytes are kept; header bytes are known constants
  always_ff @(posedge clk) begin
    if (in_xfer && phase >= PH_DATA && phase <= PH_LAST) begin
      frame_store[phase] <= rx_byte;
    end
  end

  // ---------------------------------------------------------------- slot match
  logic [7:0]           node_id;
  logic [MAX_SLOTS-1:0] match;

  assign node_id = {frame_store[IDX_ID_HI][2:0], frame_store[IDX_ID_LO][7:3]};

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      match[k] = (slot_count > 4'(k)) && (slot_id_table[8*k +: 8] == node_id);
    end
  end

  // ---------------------------------------------------------------- arithmetic pipeline
  // lanes: min + floor((raw * span + 32767) / 65535), then saturate
  raw_t                     s0_raw [LANES];
  raw_t                     s0_traw;
  logic [MAX_SLOTS-1:0]     s0_mask;

  logic signed [32:0]       s1_span [LANES];
  raw_t                     s1_raw [LANES];
  logic [28:0]              s1_tp;
  logic [18:0]              s1_ty;
  logic [MAX_SLOTS-1:0]     s1_mask;

  logic signed [49:0]       s2_prod [LANES];
  logic [28:0]              s2_tp;
  logic [38:0]              s2_td;
  logic [MAX_SLOTS-1:0]     s2_mask;

  logic [50:0]              s3_x [LANES];
  temp_t                    s3_te;
  logic [MAX_SLOTS-1:0]     s3_mask;

  logic [35:0]              s4_t [LANES];
  logic [17:0]              s4_xlo [LANES];
  temp_t                    s4_te;
  logic [MAX_SLOTS-1:0]     s4_mask;

  logic [35:0]              s5_t [LANES];
  logic [1:0]               s5_corr [LANES];
  temp_t                    s5_te;
  logic [MAX_SLOTS-1:0]     s5_mask;

  logic signed [35:0]       s6_qm [LANES];
  temp_t                    s6_te;
  logic [MAX_SLOTS-1:0]     s6_mask;

  logic [17:0]              rem [LANES];
  logic signed [36:0]       sum7 [LANES];
  q16_t                     res_val [LANES];
  temp_t                    res_temp;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // remainder is known to sit below 4 * 65535, so 18 bits carry it exactly
      rem[l]  = s4_xlo[l] - {s4_t[l][1:0], 16'h0000} + s4_t[l][17:0];
      sum7[l] = 37'(lane_lo[l]) + 37'(s6_qm[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= '0;
    end else begin
      s_vld <= {s_vld[STAGES-2:0], launch};
    end
  end

  always_ff @(posedge clk) begin
    // stage 0: raw fields out of the frame
    s0_raw[LANE_POS] <= {frame_store[IDX_POS], frame_store[IDX_POS+1]};
    s0_raw[LANE_VEL] <= {frame_store[IDX_VEL], frame_store[IDX_VEL+1]};
    s0_raw[LANE_TRQ] <= {frame_store[IDX_TRQ], frame_store[IDX_TRQ+1]};
    s0_traw          <= {frame_store[IDX_TMP], frame_store[IDX_TMP+1]};
    s0_mask          <= match;

    // stage 1: span, temperature split
    for (int l = 0; l < LANES; l++) begin
      s1_span[l] <= 33'(lane_hi[l]) - 33'(lane_lo[l]);
      s1_raw[l]  <= s0_raw[l];
    end
    s1_tp   <= 29'(s0_traw) * TEMP_MUL;
    s1_ty   <= 19'(s0_traw) * TEMP_SIX + TEMP_RND;
    s1_mask <= s0_mask;

    // stage 2: raw * span
    for (int l = 0; l < LANES; l++) begin
      s2_prod[l] <= 50'(signed'({1'b0, s1_raw[l]})) * 50'(s1_span[l]);
    end
    s2_tp   <= s1_tp;
    s2_td   <= 39'(s1_ty) * RECIP10;
    s2_mask <= s1_mask;

    // stage 3: rounding offset plus positive bias
    for (int l = 0; l < LANES; l++) begin
      s3_x[l] <= 51'(51'(s2_prod[l]) + 51'(HALF_STEP) + DIV_BIAS);
    end
    s3_te   <= s2_tp + 29'(s2_td[38:RECIP10_SH]);
    s3_mask <= s2_mask;

    // stage 4: quotient estimate by digit sums, low three short
    for (int l = 0; l < LANES; l++) begin
      s4_t[l]   <= 36'(s3_x[l][50:16]) + 36'(s3_x[l][50:32]) + 36'(s3_x[l][50:48]);
      s4_xlo[l] <= s3_x[l][17:0];
    end
    s4_te   <= s3_te;
    s4_mask <= s3_mask;

    // stage 5: correction from the remainder
    for (int l = 0; l < LANES; l++) begin
      s5_t[l] <= s4_t[l];
      priority if (rem[l] >= DIV_C3) begin
        s5_corr[l] <= 2'd3;
      end else if (rem[l] >= DIV_C2) begin
        s5_corr[l] <= 2'd2;
      end else if (rem[l] >= DIV_C1) begin
        s5_corr[l] <= 2'd1;
      end else begin
        s5_corr[l] <= 2'd0;
      end
    end
    s5_te   <= s4_te;
    s5_mask <= s4_mask;

    // stage 6: exact floor quotient, bias removed
    for (int l = 0; l < LANES; l++) begin
      s6_qm[l] <= signed'(s5_t[l] + 36'(s5_corr[l]) - Q_BIAS);
    end
    s6_te   <= s5_te;
    s6_mask <= s5_mask;

    // stage 7: add range minimum and saturate into the result register
    if (s_vld[STAGES-1]) begin
      for (int l = 0; l < LANES; l++) begin
        if (sum7[l] > 37'sd2147483647) begin
          res_val[l] <= 32'sh7FFF_FFFF;
        end else if (sum7[l] < -37'sd2147483648) begin
          res_val[l] <= 32'sh8000_0000;
        end else begin
          res_val[l] <= sum7[l][31:0];
        end
      end
      res_temp <= s6_te;
    end
  end

  // ---------------------------------------------------------------- result emitter
  // one result per matching slot, lowest slot first
  logic [MAX_SLOTS-1:0] first_oh;
  logic                 out_xfer;

  assign first_oh = pend & (~pend + MAX_SLOTS'(1));
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    pend_next = pend;
    if (s_vld[STAGES-1]) begin
      pend_next = s6_mask;
    end else if (out_xfer) begin
      pend_next = pend & ~first_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  always_comb begin
    motor_slot = 3'd0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (first_oh[k]) begin
        motor_slot = 3'(k);
      end
    end
  end

  assign out_valid     = |pend;
  assign last_of_frame = ((pend & ~first_oh) == '0);
  assign position_val  = res_val[LANE_POS];
  assign speed_val     = res_val[LANE_VEL];
  assign torque_val    = res_val[LANE_TRQ];
  assign temp_val      = res_temp;

  // ---------------------------------------------------------------- checks
  // only one frame at a time travels the pipeline
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    $countones(s_vld) <= 1)
    else $error("more than one frame in the arithmetic pipeline");

  // results of a frame are never overwritten by the next one
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s_vld[STAGES-1] |-> (pend == '0))
    else $error("result register loaded while results still pending");

  // the last result of a frame empties the emitter
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && last_of_frame) |=> !out_valid)
    else $error("results left after last_of_frame transfer");

endmodule
